// ===== rtl/jets_pkg.sv =====
// Shared types, constants and helpers for the Julia escape-time pixel unit.
// No dependencies; every other file in rtl/ imports this package.
package jets_pkg;

   localparam int IMAGE_WIDTH_DEFAULT  = 1024;
   localparam int IMAGE_HEIGHT_DEFAULT = 1024;
   localparam int MAX_ITER_DEFAULT     = 32;

   // 3 * 2^24: scale of the coordinate map, z = floor(MAP_SCALE*coord/size) - MAP_SCALE/2
   localparam longint unsigned MAP_SCALE  = 64'd50331648;
   localparam logic [63:0]     ESCAPE_SQ  = 64'd1 << 50;
   localparam logic [7:0]      ALPHA_CONST = 8'd30;

   typedef enum logic [0:0] {
      CSR_C_REAL = 1'b0,
      CSR_C_IMAG = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [5:0] iterations;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] zx;
      logic signed [31:0] zy;
   } zpoint_type;

   localparam logic [7:0] GREEN_TAB [0:32] = '{
      8'd0,   8'd24,  8'd49,  8'd73,  8'd97,  8'd120, 8'd141, 8'd161,
      8'd180, 8'd197, 8'd211, 8'd224, 8'd235, 8'd243, 8'd250, 8'd253,
      8'd254, 8'd253, 8'd250, 8'd244, 8'd235, 8'd225, 8'd212, 8'd197,
      8'd180, 8'd162, 8'd141, 8'd120, 8'd97,  8'd74,  8'd50,  8'd25,
      8'd0
   };

   localparam logic [7:0] BLUE_TAB [0:32] = '{
      8'd0,   8'd45,  8'd63,  8'd78,  8'd90,  8'd100, 8'd110, 8'd119,
      8'd127, 8'd135, 8'd142, 8'd149, 8'd156, 8'd162, 8'd168, 8'd174,
      8'd180, 8'd185, 8'd191, 8'd196, 8'd201, 8'd206, 8'd211, 8'd216,
      8'd220, 8'd225, 8'd229, 8'd234, 8'd238, 8'd242, 8'd246, 8'd250,
      8'd255
   };

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/jets_map.sv =====
// Coordinate map: pixel index to signed Q8.24 plane coordinate, three register stages.
// Depends on jets_pkg (MAP_SCALE, sat32).
module jets_map #(
   parameter int SIZE = 1024
) (
   input  logic               clock,
   input  logic               en,
   input  logic [9:0]         coord_i,
   output logic signed [31:0] z_o
);
   import jets_pkg::*;

   // MAP_SCALE*coord/SIZE = coord*QUOT + coord*REM/SIZE; the last term by reciprocal
   localparam longint unsigned QUOT_L  = MAP_SCALE / SIZE;
   localparam longint unsigned REM_L   = MAP_SCALE % SIZE;
   localparam longint unsigned RECIP_L = ((64'd1 << 36) + 64'(SIZE) - 64'd1) / 64'(SIZE);
   localparam logic [21:0] MAP_QUOT  = 22'(QUOT_L);
   localparam logic [11:0] MAP_REM   = 12'(REM_L);
   localparam logic [32:0] MAP_RECIP = 33'(RECIP_L);
   localparam logic signed [63:0] MAP_HALF = 64'sd25165824;

   logic [31:0]        hi1_ff,  hi1_in;
   logic [21:0]        rem1_ff, rem1_in;
   logic [31:0]        hi2_ff;
   logic [54:0]        quo2_ff, quo2_in;
   logic signed [63:0] sum_in;
   logic signed [31:0] z_ff;

   always_comb begin
      hi1_in  = 32'(coord_i) * 32'(MAP_QUOT);
      rem1_in = 22'(coord_i) * 22'(MAP_REM);
      quo2_in = 55'(rem1_ff) * 55'(MAP_RECIP);
      sum_in  = $signed({32'd0, hi2_ff}) + $signed(64'(quo2_ff >> 36)) - MAP_HALF;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi1_ff  <= hi1_in;
         rem1_ff <= rem1_in;
         hi2_ff  <= hi1_ff;
         quo2_ff <= quo2_in;
         z_ff    <= sat32(sum_in);
      end
   end

   assign z_o = z_ff;

endmodule

// ===== rtl/jets_iter.sv =====
// One escape-time iteration: products in the first stage, test and update in the second.
// Depends on jets_pkg (zpoint_type, ESCAPE_SQ, sat32).
module jets_iter #(
   parameter int NW = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic signed [31:0]    c_real,
   input  logic signed [31:0]    c_imag,
   input  logic                  valid_i,
   input  jets_pkg::zpoint_type  z_i,
   input  logic [NW-1:0]         n_i,
   input  logic                  active_i,
   output logic                  valid_o,
   output jets_pkg::zpoint_type  z_o,
   output logic [NW-1:0]         n_o,
   output logic                  active_o
);
   import jets_pkg::*;

   logic               a_valid_ff;
   logic signed [63:0] sx_ff, sy_ff, sxy_ff;
   logic [NW-1:0]      a_n_ff;
   logic               a_active_ff;

   logic               b_valid_ff;
   zpoint_type         b_z_ff, b_z_in;
   logic [NW-1:0]      b_n_ff, b_n_in;
   logic               b_active_ff, b_active_in;

   logic [63:0]        mag_in;
   logic               escape_in;

   always_comb begin
      mag_in      = $unsigned(sx_ff) + $unsigned(sy_ff);
      escape_in   = (mag_in >= ESCAPE_SQ);
      b_active_in = a_active_ff && !escape_in;
      b_n_in      = b_active_in ? a_n_ff + NW'(1) : a_n_ff;
      // z is dead once the point escapes, so update it unconditionally
      b_z_in.zx   = sat32(((sx_ff - sy_ff) >>> 24) + 64'(c_real));
      b_z_in.zy   = sat32((sxy_ff >>> 23) + 64'(c_imag));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= valid_i;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff       <= 64'(z_i.zx) * 64'(z_i.zx);
         sy_ff       <= 64'(z_i.zy) * 64'(z_i.zy);
         sxy_ff      <= 64'(z_i.zx) * 64'(z_i.zy);
         a_n_ff      <= n_i;
         a_active_ff <= active_i;
         b_z_ff      <= b_z_in;
         b_n_ff      <= b_n_in;
         b_active_ff <= b_active_in;
      end
   end

   assign valid_o  = b_valid_ff;
   assign z_o      = b_z_ff;
   assign n_o      = b_n_ff;
   assign active_o = b_active_ff;

endmodule

// ===== rtl/julia_escape_time_pixel_unit.sv =====
// Top level of the Julia escape-time pixel unit: map, iteration pipeline, colorizer.
// Depends on jets_pkg, jets_map and jets_iter.
//
// Usage:
//   req_valid/req_ready/req_payload carry one pixel item (pixel_x, pixel_y).
//   rsp_valid/rsp_ready/rsp_payload return one colored item per pixel, in order:
//   iteration count, red, green, blue and the constant alpha.
//   csr_write_en/csr_index/csr_data set the Julia constant (c_real, c_imag, Q8.24);
//   write them only while no item is in flight. Unknown indexes cannot occur.
// Throughput: one item per cycle, sustained, as long as the receiver takes items.
// Depth: 2*MAX_ITER + 5 register stages, in order: three stages of coordinate
//   map, two stages per iteration (products, then escape test and update), one
//   stage of color products and the output register. Every iteration has its own
//   stage pair, so MAX_ITER, not the count a pixel reaches, sets the depth.
// Stall: the whole pipeline holds while a result waits and rsp_ready is low;
//   req_ready then drops, and nothing is lost or repeated.
// Reset: synchronous, clears all valid bits and loads the default Julia constant.
module julia_escape_time_pixel_unit #(
   parameter int IMAGE_WIDTH  = jets_pkg::IMAGE_WIDTH_DEFAULT,
   parameter int IMAGE_HEIGHT = jets_pkg::IMAGE_HEIGHT_DEFAULT,
   parameter int MAX_ITER     = jets_pkg::MAX_ITER_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  jets_pkg::req_type       req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output jets_pkg::rsp_type       rsp_payload,
   input  logic                    csr_write_en,
   input  jets_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_data
);
   import jets_pkg::*;

   localparam int NW = $clog2(MAX_ITER + 1);
   // floor(v / MAX_ITER) = (v * COLOR_M) >> 25, exact for v below 2^16
   localparam longint unsigned COLOR_M_L =
      ((64'd1 << 25) + 64'(MAX_ITER) - 64'd1) / 64'(MAX_ITER);
   localparam logic [25:0] COLOR_M = 26'(COLOR_M_L);

   // Global advance: every stage moves when the output register can take an item
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Julia constant registers
   logic signed [31:0] c_real_ff, c_imag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff <= -32'sd11744051;
         c_imag_ff <= 32'sd4532346;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_C_REAL: c_real_ff <= csr_data;
            CSR_C_IMAG: c_imag_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Coordinate map: valid bits follow the three map stages
   logic [2:0]         map_valid_ff;
   logic signed [31:0] map_zx, map_zy;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 3'b000;
      end else if (en) begin
         map_valid_ff <= {map_valid_ff[1:0], req_valid};
      end
   end

   jets_map #(.SIZE(IMAGE_WIDTH)) u_map_x (
      .clock   (clock),
      .en      (en),
      .coord_i (req_payload.pixel_x),
      .z_o     (map_zx)
   );

   jets_map #(.SIZE(IMAGE_HEIGHT)) u_map_y (
      .clock   (clock),
      .en      (en),
      .coord_i (req_payload.pixel_y),
      .z_o     (map_zy)
   );

   // Iteration pipeline: one stage pair per iteration, MAX_ITER pairs in all
   logic          it_valid  [0:MAX_ITER];
   zpoint_type    it_z      [0:MAX_ITER];
   logic [NW-1:0] it_n      [0:MAX_ITER];
   logic          it_active [0:MAX_ITER];

   assign it_valid[0]  = map_valid_ff[2];
   assign it_z[0].zx   = map_zx;
   assign it_z[0].zy   = map_zy;
   assign it_n[0]      = '0;
   assign it_active[0] = 1'b1;

   for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
      jets_iter #(.NW(NW)) u_iter (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .c_real   (c_real_ff),
         .c_imag   (c_imag_ff),
         .valid_i  (it_valid[k]),
         .z_i      (it_z[k]),
         .n_i      (it_n[k]),
         .active_i (it_active[k]),
         .valid_o  (it_valid[k+1]),
         .z_o      (it_z[k+1]),
         .n_o      (it_n[k+1]),
         .active_o (it_active[k+1])
      );
   end

   // Color stage one: products for red and for the table index
   logic          col_valid_ff;
   logic [NW-1:0] col_n_ff;
   logic [41:0]   red_prod_ff, red_prod_in;
   logic [41:0]   idx_prod_ff, idx_prod_in;
   logic [15:0]   n_ext, red_num, idx_num;

   always_comb begin
      n_ext       = 16'(it_n[MAX_ITER]);
      red_num     = 16'(n_ext * 16'd255);
      idx_num     = 16'(n_ext << 5);
      red_prod_in = 42'(red_num) * 42'(COLOR_M);
      idx_prod_in = 42'(idx_num) * 42'(COLOR_M);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= 1'b0;
      end else if (en) begin
         col_valid_ff <= it_valid[MAX_ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_n_ff    <= it_n[MAX_ITER];
         red_prod_ff <= red_prod_in;
         idx_prod_ff <= idx_prod_in;
      end
   end

   // Color stage two: table lookup into the output register
   logic [16:0] idx_wide;
   logic [5:0]  idx;
   rsp_type     rsp_in, rsp_ff;
   logic        rsp_valid_ff;

   always_comb begin
      idx_wide = 17'(idx_prod_ff >> 25);
      // hold the index inside the tables
      idx      = (idx_wide > 17'd32) ? 6'd32 : idx_wide[5:0];
      rsp_in.iterations = 6'(col_n_ff);
      rsp_in.red        = 8'(red_prod_ff >> 25);
      rsp_in.green      = GREEN_TAB[idx];
      rsp_in.blue       = BLUE_TAB[idx];
      rsp_in.alpha      = ALPHA_CONST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= col_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/jets_checker.sv =====
// Port-level checks for the Julia escape-time pixel unit, bound to the top level.
// Depends on jets_pkg and julia_escape_time_pixel_unit.
module jets_checker #(
   parameter int MAX_ITER = jets_pkg::MAX_ITER_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input jets_pkg::rsp_type       rsp_payload
);
   import jets_pkg::*;

   // A waiting item holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed or dropped while stalled");

   // Input is taken exactly when the output side can advance
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready disagrees with output stall");

   a_alpha_const: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.alpha == ALPHA_CONST)
      else $error("alpha is not the constant");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (MAX_ITER < 64) |-> rsp_payload.iterations <= 6'(MAX_ITER))
      else $error("iteration count beyond limit");

   // Immediate escape gives black
   a_zero_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.iterations == 6'd0 && (MAX_ITER < 64) |->
         rsp_payload.red == 8'd0 && rsp_payload.green == 8'd0 && rsp_payload.blue == 8'd0)
      else $error("zero count with nonzero color");

endmodule

bind julia_escape_time_pixel_unit jets_checker #(.MAX_ITER(MAX_ITER)) u_jets_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for julia_escape_time_pixel_unit: random pixel stream, own escape-time model.
// Depends on rtl/jets_pkg.sv and rtl/julia_escape_time_pixel_unit.sv.
module tb;

   import jets_pkg::*;

   localparam int  IMAGE_WIDTH  = IMAGE_WIDTH_DEFAULT;
   localparam int  IMAGE_HEIGHT = IMAGE_HEIGHT_DEFAULT;
   localparam int  MAX_ITER     = MAX_ITER_DEFAULT;
   localparam int  PIPE_DEPTH   = 2 * MAX_ITER + 5;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam logic signed [31:0] C_REAL_AT_RESET = -32'sd11744051;
   localparam logic signed [31:0] C_IMAG_AT_RESET = 32'sd4532346;

   // Color ramps indexed by the iteration count scaled to 0..32.
   localparam logic [7:0] SINE_RAMP [0:32] = '{
      8'd0,   8'd24,  8'd49,  8'd73,  8'd97,  8'd120, 8'd141, 8'd161,
      8'd180, 8'd197, 8'd211, 8'd224, 8'd235, 8'd243, 8'd250, 8'd253,
      8'd254, 8'd253, 8'd250, 8'd244, 8'd235, 8'd225, 8'd212, 8'd197,
      8'd180, 8'd162, 8'd141, 8'd120, 8'd97,  8'd74,  8'd50,  8'd25,
      8'd0
   };
   localparam logic [7:0] ROOT_RAMP [0:32] = '{
      8'd0,   8'd45,  8'd63,  8'd78,  8'd90,  8'd100, 8'd110, 8'd119,
      8'd127, 8'd135, 8'd142, 8'd149, 8'd156, 8'd162, 8'd168, 8'd174,
      8'd180, 8'd185, 8'd191, 8'd196, 8'd201, 8'd206, 8'd211, 8'd216,
      8'd220, 8'd225, 8'd229, 8'd234, 8'd238, 8'd242, 8'd246, 8'd250,
      8'd255
   };

   typedef enum logic [1:0] {
      TAKE_ALL,
      TAKE_HALF,
      TAKE_QUARTER,
      TAKE_TRICKLE
   } drain_style_type;

   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_ready;
   req_type       req_payload  = '0;
   logic          rsp_valid;
   logic          rsp_ready    = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index    = CSR_C_REAL;
   logic [31:0]   csr_data     = '0;

   // Julia constant as the block holds it; only changed while nothing is in flight.
   logic signed [31:0] c_real_now = C_REAL_AT_RESET;
   logic signed [31:0] c_imag_now = C_IMAG_AT_RESET;

   req_type pending_pixels [$];
   rsp_type colors_due [$];

   int mismatches  = 0;
   int cycle_count = 0;

   julia_escape_time_pixel_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Escape-time model
   // ---------------------------------------------------------------------------

   // Clamp to the signed Q8.24 range.
   function automatic longint clamp_q824(input longint v);
      longint r;
      if (v > 64'sd2147483647) begin
         r = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         r = -64'sd2147483648;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Map a pixel coordinate to the plane: floor(3*(2*coord - size)*2^23 / size).
   function automatic longint plane_coord(input int unsigned coord, input int size);
      longint num;
      longint q;
      num = (2 * longint'(coord) - longint'(size)) * 3 * (longint'(1) << 23);
      q = num / size;
      if ((num % size) != 0 && num < 0) begin
         q = q - 1;
      end
      return clamp_q824(q);
   endfunction

   function automatic rsp_type color_pixel(input req_type pixel,
                                           input logic signed [31:0] cr,
                                           input logic signed [31:0] ci);
      longint      zx;
      longint      zy;
      longint      sq_x;
      longint      sq_y;
      longint      next_x;
      logic [63:0] mag_sq;
      int unsigned count;
      int unsigned shade;
      bit          escaped;
      rsp_type     color;
      zx = plane_coord(pixel.pixel_x, IMAGE_WIDTH);
      zy = plane_coord(pixel.pixel_y, IMAGE_HEIGHT);
      count = 0;
      escaped = 1'b0;
      while (!escaped && count < MAX_ITER) begin
         sq_x = zx * zx;
         sq_y = zy * zy;
         // both squares are at most 2^62, so the 64-bit pattern of the sum is exact
         mag_sq = sq_x + sq_y;
         if (mag_sq >= ESCAPE_SQ) begin
            escaped = 1'b1;
         end else begin
            next_x = clamp_q824(((sq_x - sq_y) >>> 24) + longint'(cr));
            zy = clamp_q824(((zx * zy) >>> 23) + longint'(ci));
            zx = next_x;
            count++;
         end
      end
      shade = (count * 32) / MAX_ITER;
      if (shade > 32) begin
         shade = 32;
      end
      color.iterations = count[5:0];
      color.red = 8'((255 * count) / MAX_ITER);
      color.green = SINE_RAMP[shade];
      color.blue = ROOT_RAMP[shade];
      color.alpha = 8'd30;
      return color;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: bursts of items with random gaps between them
   // ---------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // Predict on acceptance, with the constant the block holds right now.
         if (req_valid && req_ready) begin
            colors_due.push_back(color_pixel(req_payload, c_real_now, c_imag_now));
         end
         // Hold the item while the block refuses it; otherwise advance.
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_payload <= pending_pixels.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  // New burst; about a third of them follow with no gap at all.
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: stall pattern whose style changes after a random run of cycles
   // ---------------------------------------------------------------------------
   drain_style_type drain_style = TAKE_ALL;
   int              style_left  = 0;

   always @(posedge clock) begin
      if (style_left == 0) begin
         drain_style = drain_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(16, 96);
      end else begin
         style_left--;
      end
      case (drain_style)
         TAKE_ALL: begin
            rsp_ready <= 1'b1;
         end
         TAKE_HALF: begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end
         TAKE_QUARTER: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= (style_left % 8 == 0);
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Monitor: compare each accepted result with the oldest prediction
   // ---------------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (colors_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none, actual %p", $time, rsp_payload);
         end else begin
            want = colors_due.pop_front();
            check_field("iterations", want.iterations, rsp_payload.iterations);
            check_field("red", want.red, rsp_payload.red);
            check_field("green", want.green, rsp_payload.green);
            check_field("blue", want.blue, rsp_payload.blue);
            check_field("alpha", want.alpha, rsp_payload.alpha);
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------------
   task automatic push_pixel(input int unsigned x, input int unsigned y);
      req_type pixel;
      pixel.pixel_x = x[9:0];
      pixel.pixel_y = y[9:0];
      pending_pixels.push_back(pixel);
   endtask

   // Mostly the middle of the image, where orbits run long; the rest anywhere.
   task automatic push_random_pixels(input int count);
      repeat (count) begin
         if ($urandom_range(0, 2) == 0) begin
            push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
         end else begin
            push_pixel($urandom_range(192, 831), $urandom_range(192, 831));
         end
      end
   endtask

   // Wait until every queued item is taken and every prediction has been matched.
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || colors_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_constant(input csr_index_type which, input logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= which;
      csr_data <= value;
      if (which == CSR_C_REAL) begin
         c_real_now = value;
      end else begin
         c_imag_now = value;
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Reprogram the constant with the pipeline empty, then queue a batch of pixels.
   task automatic run_frame(input logic [31:0] cr, input logic [31:0] ci, input int count);
      wait_idle();
      write_constant(CSR_C_REAL, cr);
      write_constant(CSR_C_IMAG, ci);
      @(negedge clock);
      push_random_pixels(count);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pixels under the constant loaded at reset: corners, edges, the
      // center (z = 0), its neighbors and alternating bit patterns.
      push_pixel(0, 0);
      push_pixel(1023, 1023);
      push_pixel(0, 1023);
      push_pixel(1023, 0);
      push_pixel(512, 512);
      push_pixel(511, 512);
      push_pixel(512, 511);
      push_pixel(513, 513);
      push_pixel(511, 511);
      push_pixel(10'h2AA, 10'h155);
      push_pixel(10'h155, 10'h2AA);
      push_pixel(768, 512);
      push_pixel(256, 768);
      push_pixel(0, 512);
      push_pixel(512, 1023);
      push_pixel(600, 470);

      // Hold off until the directed part has fully drained, then go random.
      wait_idle();
      push_random_pixels(240);

      // Zero constant: the unit disk never escapes, so long orbits run to the limit.
      run_frame(32'h0000_0000, 32'h0000_0000, 120);
      // Extreme constants drive the orbit into saturation.
      run_frame(32'h8000_0000, 32'h7FFF_FFFF, 60);
      run_frame(32'h7FFF_FFFF, 32'h8000_0000, 60);
      // A well-known connected Julia set, -0.8 + 0.156i.
      run_frame(-32'sd13421773, 32'sd2617246, 200);
      // Random constants from -2 to 2 per component, both bounds included.
      repeat (3) begin
         run_frame(32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000,
                   32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000, 120);
      end

      wait_idle();
      // Let any stray result show up before the verdict.
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
